FILE: sv/ctse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctse_pkg
// shared constants, codes and control types of the chebyshev series evaluator
// ----------------------------------------------------------------------------
package ctse_pkg;

   localparam int ORDER_DEF      = 7;
   localparam int DIMENSIONS_DEF = 3;
   localparam int MAX_DIMS       = 3;
   localparam int STORE_DEPTH    = 512;

   localparam int IDX_W   = 9;
   localparam int COEF_W  = 32;
   localparam int COORD_W = 16;
   localparam int CHEB_W  = 32;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int RES_W   = 34;
   localparam int STEP_W  = 34;
   localparam int ACC_W   = 50;
   localparam int VAL_W   = 48;
   localparam int DSEL_W  = 2;

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 48;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd16384;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -16'sd16384;

   localparam logic signed [CHEB_W-1:0] ONE_Q30  = 32'sh4000_0000;
   localparam logic signed [CHEB_W-1:0] MONE_Q30 = -32'sh4000_0000;
   localparam logic signed [STEP_W-1:0] STEP_MAX = 34'sh0_4000_0000;
   localparam logic signed [STEP_W-1:0] STEP_MIN = -34'sh0_4000_0000;

   localparam logic signed [ACC_W-1:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] SUM_MIN = -50'sh0_8000_0000_0000;
   localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic {
      SH_Q14 = 1'b0,
      SH_Q30 = 1'b1
   } shift_type;

   typedef enum logic [1:0] {
      A_COORD = 2'd0,
      A_PROD  = 2'd1,
      A_RES   = 2'd2,
      A_COEF  = 2'd3
   } a_sel_type;

   typedef enum logic [1:0] {
      B_T1   = 2'd0,
      B_CHEB = 2'd1,
      B_PROD = 2'd2,
      B_RES  = 2'd3
   } b_sel_type;

   typedef enum logic [1:0] {
      W_ONE   = 2'd0,
      W_COORD = 2'd1,
      W_STEP  = 2'd2
   } wsel_type;

   typedef struct packed {
      logic      idle;
      logic      cheb_we;
      wsel_type  wsel;
      a_sel_type a_sel;
      b_sel_type b_sel;
      shift_type shift;
      logic      prod_load;
      logic      acc_clear;
      logic      acc_add;
      logic      out_load;
   } ctl_type;

   // number of summed terms: (order+1)^dims, capped at the store depth
   function automatic int series_terms(input int order, input int dims);
      int t;
      t = 1;
      for (int d = 0; d < dims; d++) begin
         t = t * (order + 1);
         if (t > STORE_DEPTH) begin
            t = STORE_DEPTH;
         end
      end
      return t;
   endfunction

endpackage

FILE: sv/ctse_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctse_mul
// shared signed 32x32 multiplier with a registered round-half-up shift stage
// ----------------------------------------------------------------------------
module ctse_mul (
   input  logic                                 clock,
   input  logic signed [ctse_pkg::MUL_W-1:0]    a,
   input  logic signed [ctse_pkg::MUL_W-1:0]    b,
   input  ctse_pkg::shift_type                  shift,
   output logic signed [ctse_pkg::RES_W-1:0]    res
);

   logic signed [ctse_pkg::PROD_W-1:0] prod_ff;
   logic signed [ctse_pkg::PROD_W-1:0] prod_in;
   ctse_pkg::shift_type                shift_ff;
   logic signed [ctse_pkg::PROD_W-1:0] rsum;
   logic signed [ctse_pkg::PROD_W-1:0] rshift;
   logic signed [ctse_pkg::RES_W-1:0]  res_ff;
   logic signed [ctse_pkg::RES_W-1:0]  res_in;

   assign prod_in = a * b;

   always_comb begin
      case (shift_ff)
         ctse_pkg::SH_Q14: begin
            rsum   = prod_ff + (64'sd1 <<< 13);
            rshift = rsum >>> 14;
         end
         ctse_pkg::SH_Q30: begin
            rsum   = prod_ff + (64'sd1 <<< 29);
            rshift = rsum >>> 30;
         end
         default: begin
            rsum   = prod_ff;
            rshift = prod_ff;
         end
      endcase
      res_in = rshift[ctse_pkg::RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift;
      res_ff   <= res_in;
   end

   assign res = res_ff;

endmodule

FILE: sv/ctse_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctse_seq
// sequencer: recurrence setup per dimension, then one term after another
// ----------------------------------------------------------------------------
module ctse_seq #(
   parameter int ORDER      = ctse_pkg::ORDER_DEF,
   parameter int DIMENSIONS = ctse_pkg::DIMENSIONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  out_free,
   output ctse_pkg::ctl_type                     ctl,
   output logic [ctse_pkg::DSEL_W-1:0]           dim_sel,
   output logic [$clog2(DIMENSIONS*(ORDER+1))-1:0] cheb_waddr,
   output logic [$clog2(DIMENSIONS*(ORDER+1))-1:0] cheb_raddr,
   output logic [ctse_pkg::IDX_W-1:0]            coef_raddr
);

   localparam int BASE  = ORDER + 1;
   localparam int DIG_W = $clog2(BASE);
   localparam int CH_AW = $clog2(DIMENSIONS * BASE);
   localparam int TERMS = ctse_pkg::series_terms(ORDER, DIMENSIONS);
   localparam int TM_W  = ctse_pkg::IDX_W;
   localparam int DS_W  = ctse_pkg::DSEL_W;
   localparam int ND    = ctse_pkg::MAX_DIMS;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0_0000_0000_0001,
      S_CINIT = 13'b0_0000_0000_0010,
      S_CONE  = 13'b0_0000_0000_0100,
      S_CMUL  = 13'b0_0000_0000_1000,
      S_CWAIT = 13'b0_0000_0001_0000,
      S_CRND  = 13'b0_0000_0010_0000,
      S_TLD   = 13'b0_0000_0100_0000,
      S_TPM   = 13'b0_0000_1000_0000,
      S_TPW   = 13'b0_0001_0000_0000,
      S_TCM   = 13'b0_0010_0000_0000,
      S_TCW   = 13'b0_0100_0000_0000,
      S_TACC  = 13'b0_1000_0000_0000,
      S_DONE  = 13'b1_0000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [DS_W-1:0]   dsel_ff, dsel_in;
   logic [DIG_W-1:0]  n_ff, n_in;
   logic [DIG_W-1:0]  digit_ff [ND];
   logic [DIG_W-1:0]  digit_in [ND];
   logic [TM_W-1:0]   term_ff, term_in;
   ctse_pkg::ctl_type ctl_c;

   always_comb begin
      logic last_step;
      logic carry;
      last_step = 1'b0;
      carry     = 1'b1;
      state_in  = state_ff;
      dsel_in   = dsel_ff;
      n_in      = n_ff;
      digit_in  = digit_ff;
      term_in   = term_ff;

      ctl_c.idle      = 1'b0;
      ctl_c.cheb_we   = 1'b0;
      ctl_c.wsel      = ctse_pkg::W_ONE;
      ctl_c.a_sel     = ctse_pkg::A_COORD;
      ctl_c.b_sel     = ctse_pkg::B_T1;
      ctl_c.shift     = ctse_pkg::SH_Q30;
      ctl_c.prod_load = 1'b0;
      ctl_c.acc_clear = 1'b0;
      ctl_c.acc_add   = 1'b0;
      ctl_c.out_load  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            ctl_c.idle = 1'b1;
            if (start) begin
               ctl_c.acc_clear = 1'b1;
               dsel_in  = '0;
               n_in     = '0;
               term_in  = '0;
               for (int d = 0; d < ND; d++) begin
                  digit_in[d] = '0;
               end
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            ctl_c.cheb_we = 1'b1;
            ctl_c.wsel    = ctse_pkg::W_ONE;
            n_in          = n_ff + 1'b1;
            state_in      = S_CONE;
         end
         S_CONE: begin
            ctl_c.cheb_we = 1'b1;
            ctl_c.wsel    = ctse_pkg::W_COORD;
            if (ORDER == 1) begin
               last_step = 1'b1;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_CMUL;
            end
         end
         S_CMUL: begin
            ctl_c.a_sel = ctse_pkg::A_COORD;
            ctl_c.b_sel = ctse_pkg::B_T1;
            ctl_c.shift = ctse_pkg::SH_Q14;
            state_in    = S_CWAIT;
         end
         S_CWAIT: begin
            state_in = S_CRND;
         end
         S_CRND: begin
            ctl_c.cheb_we = 1'b1;
            ctl_c.wsel    = ctse_pkg::W_STEP;
            if (n_ff == DIG_W'(ORDER)) begin
               last_step = 1'b1;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_CMUL;
            end
         end
         S_TLD: begin
            ctl_c.prod_load = 1'b1;
            if (DIMENSIONS == 1) begin
               state_in = S_TCM;
            end else begin
               dsel_in  = DS_W'(1);
               state_in = S_TPM;
            end
         end
         S_TPM: begin
            ctl_c.a_sel = (dsel_ff == DS_W'(1)) ? ctse_pkg::A_PROD : ctse_pkg::A_RES;
            ctl_c.b_sel = ctse_pkg::B_CHEB;
            ctl_c.shift = ctse_pkg::SH_Q30;
            state_in    = S_TPW;
         end
         S_TPW: begin
            if (dsel_ff == DS_W'(DIMENSIONS - 1)) begin
               state_in = S_TCM;
            end else begin
               dsel_in  = dsel_ff + 1'b1;
               state_in = S_TPM;
            end
         end
         S_TCM: begin
            ctl_c.a_sel = ctse_pkg::A_COEF;
            ctl_c.b_sel = (DIMENSIONS == 1) ? ctse_pkg::B_PROD : ctse_pkg::B_RES;
            ctl_c.shift = ctse_pkg::SH_Q30;
            state_in    = S_TCW;
         end
         S_TCW: begin
            state_in = S_TACC;
         end
         S_TACC: begin
            ctl_c.acc_add = 1'b1;
            if (term_ff == TM_W'(TERMS - 1)) begin
               state_in = S_DONE;
            end else begin
               term_in = term_ff + 1'b1;
               dsel_in = '0;
               for (int d = 0; d < ND; d++) begin
                  if (d < DIMENSIONS && carry) begin
                     if (digit_ff[d] == DIG_W'(ORDER)) begin
                        digit_in[d] = '0;
                     end else begin
                        digit_in[d] = digit_ff[d] + 1'b1;
                        carry       = 1'b0;
                     end
                  end
               end
               state_in = S_TLD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ctl_c.out_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of one dimension's recurrence
      if (last_step) begin
         n_in = '0;
         if (dsel_ff == DS_W'(DIMENSIONS - 1)) begin
            dsel_in  = '0;
            state_in = S_TLD;
         end else begin
            dsel_in  = dsel_ff + 1'b1;
            state_in = S_CINIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dsel_ff  <= '0;
         n_ff     <= '0;
         term_ff  <= '0;
         for (int d = 0; d < ND; d++) begin
            digit_ff[d] <= '0;
         end
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
         n_ff     <= n_in;
         term_ff  <= term_in;
         digit_ff <= digit_in;
      end
   end

   // read addresses follow the next counter values so data lines up with them
   assign cheb_waddr = CH_AW'(dsel_ff) * CH_AW'(BASE) + CH_AW'(n_ff);
   assign cheb_raddr = CH_AW'(dsel_in) * CH_AW'(BASE) + CH_AW'(digit_in[dsel_in]);
   assign coef_raddr = term_in;
   assign dim_sel    = dsel_ff;
   assign ctl        = ctl_c;

endmodule

FILE: sv/chebyshev_tensor_series_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_tensor_series_eval
// tensor-product chebyshev series evaluator over a 512-entry coefficient store
// ----------------------------------------------------------------------------
// req side takes one word per handshake; tuser selects load or evaluate.
// a load writes one q16.16 coefficient and is done in the accept cycle.
// an evaluate clamps the q1.14 coordinates, builds T0..T_ORDER per
// dimension with the shared multiplier, then walks every coefficient:
// product of chebyshev values, times coefficient, summed; the q16.16 sum
// clips to 48 bits with tuser flagging the clip.
// the number of terms walked is min((ORDER+1)^DIMENSIONS, 512).
// evaluate time is set by the one two-stage multiply-round unit, which each
// term's product chain and coefficient multiply go through in turn.
// req_tready is low from an evaluate's accept until its result is loaded
// into the output register; loads are taken while a result waits there.
// a stalled rsp side holds the result, and the next result waits in the
// sequencer until the register is free.
// reset clears the sequencer and output valid; coefficients are kept
// undefined until loaded.
// ----------------------------------------------------------------------------
module chebyshev_tensor_series_eval #(
   parameter int ORDER      = ctse_pkg::ORDER_DEF,
   parameter int DIMENSIONS = ctse_pkg::DIMENSIONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // coef_index, coef_value, coord_first, coord_second, coord_third, zero pad
   input  logic [ctse_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // operation
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // approx_value
   output logic [ctse_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // saturated
   output logic                                  rsp_tuser
);

   localparam int BASE     = ORDER + 1;
   localparam int CH_DEPTH = DIMENSIONS * BASE;
   localparam int CH_AW    = $clog2(CH_DEPTH);
   localparam int ND       = ctse_pkg::MAX_DIMS;
   localparam int CW       = ctse_pkg::COORD_W;
   localparam int IW       = ctse_pkg::IDX_W;
   localparam int KW       = ctse_pkg::COEF_W;
   localparam int VLO      = IW;
   localparam int CLO      = IW + KW;

   ctse_pkg::ctl_type                     ctl;
   logic [ctse_pkg::DSEL_W-1:0]           dim_sel;
   logic [CH_AW-1:0]                      cheb_waddr;
   logic [CH_AW-1:0]                      cheb_raddr;
   logic [IW-1:0]                         coef_raddr;

   logic                                  req_accept;
   logic                                  load_accept;
   logic                                  start;
   logic                                  out_free;
   logic [IW-1:0]                         req_index;
   logic signed [KW-1:0]                  req_value;
   logic signed [CW-1:0]                  coord_raw [ND];

   logic signed [CW-1:0]                  x_ff [ND];
   logic signed [CW-1:0]                  x_sel;
   logic signed [ctse_pkg::CHEB_W-1:0]    coord_q30;

   logic signed [ctse_pkg::CHEB_W-1:0]    cheb_mem [CH_DEPTH];
   logic signed [ctse_pkg::CHEB_W-1:0]    cheb_rdata_ff;
   logic signed [ctse_pkg::CHEB_W-1:0]    cheb_wdata;
   logic signed [KW-1:0]                  coef_mem [ctse_pkg::STORE_DEPTH];
   logic signed [KW-1:0]                  coef_rdata_ff;

   logic signed [ctse_pkg::CHEB_W-1:0]    t1_ff;
   logic signed [ctse_pkg::CHEB_W-1:0]    t2_ff;
   logic signed [ctse_pkg::CHEB_W-1:0]    prod_ff;
   logic signed [ctse_pkg::ACC_W-1:0]     acc_ff;

   logic signed [ctse_pkg::MUL_W-1:0]     mul_a;
   logic signed [ctse_pkg::MUL_W-1:0]     mul_b;
   logic signed [ctse_pkg::RES_W-1:0]     mul_res;
   logic signed [ctse_pkg::MUL_W-1:0]     res_lo;

   logic signed [ctse_pkg::STEP_W-1:0]    two_p;
   logic signed [ctse_pkg::STEP_W-1:0]    t2_ext;
   logic signed [ctse_pkg::STEP_W-1:0]    step_diff;
   logic signed [ctse_pkg::CHEB_W-1:0]    step_val;

   logic [ctse_pkg::VAL_W-1:0]            sum_val;
   logic                                  sum_sat;

   logic                                  rsp_valid_ff;
   logic [ctse_pkg::VAL_W-1:0]            rsp_data_ff;
   logic                                  rsp_sat_ff;

   // input word
   assign req_tready  = ctl.idle & ~reset;
   assign req_accept  = req_tvalid & req_tready;
   assign load_accept = req_accept & (req_tuser == ctse_pkg::OP_LOAD);
   assign start       = req_accept & (req_tuser == ctse_pkg::OP_EVAL);
   assign req_index   = req_tdata[IW-1:0];
   assign req_value   = req_tdata[VLO +: KW];

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         coord_raw[d] = req_tdata[CLO + d*CW +: CW];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int d = 0; d < ND; d++) begin
            if (coord_raw[d] > ctse_pkg::COORD_MAX) begin
               x_ff[d] <= ctse_pkg::COORD_MAX;
            end else if (coord_raw[d] < ctse_pkg::COORD_MIN) begin
               x_ff[d] <= ctse_pkg::COORD_MIN;
            end else begin
               x_ff[d] <= coord_raw[d];
            end
         end
      end
   end

   assign x_sel     = x_ff[dim_sel];
   assign coord_q30 = {x_sel, 16'h0000};

   ctse_seq #(
      .ORDER      (ORDER),
      .DIMENSIONS (DIMENSIONS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .out_free   (out_free),
      .ctl        (ctl),
      .dim_sel    (dim_sel),
      .cheb_waddr (cheb_waddr),
      .cheb_raddr (cheb_raddr),
      .coef_raddr (coef_raddr)
   );

   // operand selection for the shared unit
   always_comb begin
      case (ctl.a_sel)
         ctse_pkg::A_COORD: mul_a = {{(ctse_pkg::MUL_W-CW){x_sel[CW-1]}}, x_sel};
         ctse_pkg::A_PROD:  mul_a = prod_ff;
         ctse_pkg::A_RES:   mul_a = res_lo;
         ctse_pkg::A_COEF:  mul_a = coef_rdata_ff;
         default:           mul_a = prod_ff;
      endcase
      case (ctl.b_sel)
         ctse_pkg::B_T1:   mul_b = t1_ff;
         ctse_pkg::B_CHEB: mul_b = cheb_rdata_ff;
         ctse_pkg::B_PROD: mul_b = prod_ff;
         ctse_pkg::B_RES:  mul_b = res_lo;
         default:          mul_b = t1_ff;
      endcase
   end

   ctse_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .shift (ctl.shift),
      .res   (mul_res)
   );

   assign res_lo = mul_res[ctse_pkg::MUL_W-1:0];

   // recurrence step: 2*p - t(n-2), clamped to [-1, 1]
   always_comb begin
      two_p     = {res_lo[ctse_pkg::MUL_W-1], res_lo, 1'b0};
      t2_ext    = {{(ctse_pkg::STEP_W-ctse_pkg::CHEB_W){t2_ff[ctse_pkg::CHEB_W-1]}}, t2_ff};
      step_diff = two_p - t2_ext;
      if (step_diff > ctse_pkg::STEP_MAX) begin
         step_val = ctse_pkg::ONE_Q30;
      end else if (step_diff < ctse_pkg::STEP_MIN) begin
         step_val = ctse_pkg::MONE_Q30;
      end else begin
         step_val = step_diff[ctse_pkg::CHEB_W-1:0];
      end
   end

   always_comb begin
      case (ctl.wsel)
         ctse_pkg::W_ONE:   cheb_wdata = ctse_pkg::ONE_Q30;
         ctse_pkg::W_COORD: cheb_wdata = coord_q30;
         ctse_pkg::W_STEP:  cheb_wdata = step_val;
         default:           cheb_wdata = ctse_pkg::ONE_Q30;
      endcase
   end

   // chebyshev table
   always_ff @(posedge clock) begin
      if (ctl.cheb_we) begin
         cheb_mem[cheb_waddr] <= cheb_wdata;
      end
      cheb_rdata_ff <= cheb_mem[cheb_raddr];
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (load_accept) begin
         coef_mem[req_index] <= req_value;
      end
      coef_rdata_ff <= coef_mem[coef_raddr];
   end

   // recurrence history, running product, accumulator
   always_ff @(posedge clock) begin
      if (ctl.cheb_we) begin
         case (ctl.wsel)
            ctse_pkg::W_ONE: begin
               t2_ff <= ctse_pkg::ONE_Q30;
            end
            ctse_pkg::W_COORD: begin
               t1_ff <= coord_q30;
            end
            ctse_pkg::W_STEP: begin
               t2_ff <= t1_ff;
               t1_ff <= step_val;
            end
            default: begin
               t1_ff <= t1_ff;
            end
         endcase
      end
      if (ctl.prod_load) begin
         prod_ff <= cheb_rdata_ff;
      end
      if (ctl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctl.acc_add) begin
         acc_ff <= acc_ff +
            {{(ctse_pkg::ACC_W-ctse_pkg::RES_W){mul_res[ctse_pkg::RES_W-1]}}, mul_res};
      end
   end

   always_comb begin
      if (acc_ff > ctse_pkg::SUM_MAX) begin
         sum_val = ctse_pkg::VAL_MAX;
         sum_sat = 1'b1;
      end else if (acc_ff < ctse_pkg::SUM_MIN) begin
         sum_val = ctse_pkg::VAL_MIN;
         sum_sat = 1'b1;
      end else begin
         sum_val = acc_ff[ctse_pkg::VAL_W-1:0];
         sum_sat = 1'b0;
      end
   end

   // output register
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_data_ff <= sum_val;
         rsp_sat_ff  <= sum_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata == ctse_pkg::VAL_MAX || rsp_tdata == ctse_pkg::VAL_MIN))
      else $error("saturated result not at a rail");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over an untaken word");

   a_cheb_range: assert property (@(posedge clock) disable iff (reset)
      ctl.cheb_we |->
         (cheb_wdata <= ctse_pkg::ONE_Q30 && cheb_wdata >= ctse_pkg::MONE_Q30))
      else $error("chebyshev value out of range");

   a_busy_after_eval: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("ready while an evaluate is in progress");

endmodule
